FILE: src/iqr_pkg.sv
// Shared types, constants and arithmetic helpers of the incremental QR core.
package iqr_pkg;

  localparam int unsigned MaxRowsDef = 64;
  localparam int unsigned MaxColsDef = 16;
  localparam int unsigned Frac       = 29;
  // Slot field sized for the largest supported row count
  localparam int unsigned SlotW      = 10;
  // Dividend of a unit scaling: magnitude shifted up by the fraction bits
  localparam int unsigned DvdW       = 32 + Frac;
  localparam logic [6:0]  RowsReset  = 7'd64;
  localparam logic        KindR      = 1'b0;
  localparam logic        KindB      = 1'b1;

  typedef enum logic [1:0] {
    CMD_COLUMN = 2'd0,
    CMD_VECTOR = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_COLUMN = 2'd0,
    OP_VECTOR = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic               kind;
    logic [3:0]         index;
    logic signed [31:0] entry;
    logic [1:0]         status;
    logic               final_res;
  } result_t;

  // Work handed from the front end to the back end
  typedef struct packed {
    op_e                op;
    logic [SlotW-1:0]   slot;
    logic               last;
    logic signed [31:0] value;
  } work_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
    if (x > 35'sd2147483647) return 32'sh7fffffff;
    if (x < -35'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Round a Q4.58 sum back to Q2.29 (add half, floor) and saturate
  function automatic logic signed [31:0] round_q(input logic [63:0] acc);
    logic [63:0]        t;
    logic signed [63:0] s;
    t = acc + 64'd268435456;
    s = t;
    return sat32(35'(s >>> Frac));
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // Apply the sign to a unit-scaling quotient and saturate
  function automatic logic signed [31:0] scale_sat(input logic neg,
                                                   input logic [DvdW-1:0] q);
    if (!neg) begin
      if (q > DvdW'(32'h7fffffff)) return 32'sh7fffffff;
      return q[31:0];
    end
    if (q >= DvdW'(32'h80000000)) return 32'sh80000000;
    return ~q[31:0] + 32'd1;
  endfunction

endpackage

FILE: src/iqr_ram.sv
// Generic simple dual-port RAM with registered read.
module iqr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/iqr_fifo.sv
// Small register queue used between the front end, back end and result port.
module iqr_fifo #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(Depth - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(Depth - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: src/iqr_front.sv
// Front end: accepts commands, tracks the loading vector and queues work.
module iqr_front import iqr_pkg::*; #(
  parameter int unsigned MaxRows = MaxRowsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [$clog2(MaxRows+1)-1:0]   rows_i,
  input  logic                           push_i,
  input  cmd_item_t                      in_data_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output work_t                          q_data_o
);

  localparam int unsigned ECW = $clog2(MaxRows + 1);

  logic [ECW-1:0] cnt_q, cnt_d;
  logic           kind_q, kind_d;
  logic           accept;
  logic           kind_bit;
  logic [ECW-1:0] base, nxt;
  logic           last;

  assign accept   = push_i && !q_full_i;
  assign kind_bit = in_data_i.command[0];

  // Slot of the element, restarting on a change of vector kind
  always_comb begin
    base = cnt_q;
    if (cnt_q != '0 && kind_bit != kind_q) begin
      base = '0;
    end
    if (base >= ECW'(MaxRows)) begin
      base = ECW'(MaxRows - 1);
    end
    nxt  = base + ECW'(1);
    last = (nxt >= rows_i);
  end

  // Classify the command and build the queue entry
  always_comb begin
    cnt_d           = cnt_q;
    kind_d          = kind_q;
    q_push_o        = 1'b0;
    q_data_o.op     = OP_CLEAR;
    q_data_o.slot   = SlotW'(base);
    q_data_o.last   = last;
    q_data_o.value  = in_data_i.value;
    unique case (cmd_e'(in_data_i.command))
      CMD_COLUMN, CMD_VECTOR: begin
        q_push_o    = accept;
        q_data_o.op = kind_bit ? OP_VECTOR : OP_COLUMN;
        if (accept) begin
          kind_d = kind_bit;
          cnt_d  = last ? '0 : nxt;
        end
      end
      CMD_CLEAR: begin
        q_push_o = accept;
        if (accept) begin
          cnt_d = '0;
        end
      end
      CMD_NONE: begin
        q_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      kind_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      kind_q <= kind_d;
    end
  end

endmodule

FILE: src/iqr_div.sv
// Restoring divider, one quotient bit per cycle, for unit scaling.
module iqr_div import iqr_pkg::*; #(
  parameter int unsigned NormW = 36
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DvdW-1:0]   dividend_i,
  input  logic [NormW-1:0]  divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DvdW-1:0]   quotient_o
);

  localparam int unsigned NCW = $clog2(DvdW);

  logic [NormW:0]   rem_q;
  logic [DvdW-1:0]  quo_q;
  logic [NCW-1:0]   cnt_q;
  logic             busy_q, done_q;
  logic [NormW:0]   trial;
  logic             ge;

  assign trial      = {rem_q[NormW-1:0], quo_q[DvdW-1]};
  assign ge         = (trial >= {1'b0, divisor_i});
  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // Shift in one dividend bit and subtract where it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? (trial - {1'b0, divisor_i}) : trial;
      quo_q <= {quo_q[DvdW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == NCW'(DvdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + NCW'(1);
        end
      end
    end
  end

endmodule

FILE: src/iqr_back.sv
// Back end: sequences norms, scaling, projections and result transfers.
module iqr_back import iqr_pkg::*; #(
  parameter int unsigned MaxRows = MaxRowsDef,
  parameter int unsigned MaxCols = MaxColsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [$clog2(MaxRows+1)-1:0] rows_i,
  input  logic                         work_valid_i,
  input  work_t                        work_i,
  output logic                         work_pop_o,
  input  logic                         out_full_i,
  output logic                         out_push_o,
  output result_t                      out_data_o
);

  localparam int unsigned RW  = $clog2(MaxRows);
  localparam int unsigned ECW = $clog2(MaxRows + 1);
  localparam int unsigned RAW = $clog2(MaxCols);
  localparam int unsigned LW  = $clog2(MaxCols + 1);
  localparam int unsigned QAW = $clog2(MaxRows * MaxCols);
  localparam int unsigned NW  = 32 + (RW + 2) / 2;
  localparam int unsigned SW  = 2 * NW;
  localparam int unsigned SCW = $clog2(NW);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_REJECT = 10'b0000000010,
    S_SQ     = 10'b0000000100,
    S_SQRT   = 10'b0000001000,
    S_SCALE  = 10'b0000010000,
    S_RDOT   = 10'b0000100000,
    S_RES    = 10'b0001000000,
    S_STORE  = 10'b0010000000,
    S_EMIT   = 10'b0100000000,
    S_BDOT   = 10'b1000000000
  } state_e;

  state_e             state_q, state_d;
  logic [1:0]         ph_q, ph_d;
  logic [ECW-1:0]     k_q, k_d;
  logic [LW-1:0]      l_q, l_d;
  logic [LW-1:0]      cc_q, cc_d;
  logic               kind_q, kind_d;
  logic               pass_q, pass_d;
  status_e            status_q, status_d;
  logic [NW-1:0]      nrm_q, nrm_d;
  logic [SW-1:0]      sum_q, sum_d;
  logic [NW+1:0]      srem_q, srem_d;
  logic [NW-1:0]      root_q, root_d;
  logic [SCW-1:0]     scnt_q, scnt_d;
  logic [63:0]        acc_q, acc_d;
  logic signed [63:0] prod_q, prod_d;

  logic signed [31:0] buf_rd, q_rd, r_rd;
  logic               buf_we, q_we, r_we;
  logic [RW-1:0]      buf_waddr;
  logic [31:0]        buf_wdata, q_wdata, r_wdata;
  logic [QAW-1:0]     q_waddr, q_raddr;
  logic [RAW-1:0]     r_waddr;

  logic               div_start, div_busy, div_done;
  logic [DvdW-1:0]    div_quo;

  logic signed [31:0] mul_a, mul_b;
  logic [63:0]        acc_n;
  logic               k_last, l_last;
  logic [NW+3:0]      sq_t, sq_trial;
  logic               sq_ge;

  // Working vector: loaded elements, then scaled values, then residual
  iqr_ram #(.Width(32), .Depth(MaxRows)) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (k_q[RW-1:0]),
    .rdata_o (buf_rd)
  );

  // Stored Q columns, column-major
  iqr_ram #(.Width(32), .Depth(MaxRows * MaxCols)) u_qstore (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rd)
  );

  // R column of the column in progress
  iqr_ram #(.Width(32), .Depth(MaxCols)) u_rcol (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (l_q[RAW-1:0]),
    .rdata_o (r_rd)
  );

  iqr_div #(.NormW(NW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag32(buf_rd), {Frac{1'b0}}}),
    .divisor_i  (nrm_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign q_raddr  = QAW'(l_q) * QAW'(MaxRows) + QAW'(k_q);
  assign q_waddr  = QAW'(cc_q) * QAW'(MaxRows) + QAW'(k_q);
  assign k_last   = (k_q == rows_i - ECW'(1));
  assign l_last   = (l_q == cc_q - LW'(1));
  assign acc_n    = acc_q + prod_q;

  // Integer square root, one root bit per iteration
  assign sq_t     = {srem_q, sum_q[SW-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = (sq_t >= sq_trial);

  // Select multiplier operands
  always_comb begin
    mul_a = buf_rd;
    mul_b = buf_rd;
    if (state_q == S_RDOT || state_q == S_BDOT) begin
      mul_a = q_rd;
    end else if (state_q == S_RES) begin
      mul_a = r_rd;
      mul_b = q_rd;
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    ph_d       = ph_q;
    k_d        = k_q;
    l_d        = l_q;
    cc_d       = cc_q;
    kind_d     = kind_q;
    pass_d     = pass_q;
    status_d   = status_q;
    nrm_d      = nrm_q;
    sum_d      = sum_q;
    srem_d     = srem_q;
    root_d     = root_q;
    scnt_d     = scnt_q;
    acc_d      = acc_q;
    prod_d     = prod_q;
    buf_we     = 1'b0;
    buf_waddr  = k_q[RW-1:0];
    buf_wdata  = '0;
    q_we       = 1'b0;
    q_wdata    = '0;
    r_we       = 1'b0;
    r_waddr    = l_q[RAW-1:0];
    r_wdata    = '0;
    div_start  = 1'b0;
    work_pop_o = 1'b0;
    out_push_o = 1'b0;
    out_data_o = '{kind: KindR, index: 4'(l_q), entry: r_rd, status: status_q,
                   final_res: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (work_valid_i) begin
          work_pop_o = 1'b1;
          unique case (work_i.op)
            OP_CLEAR: begin
              cc_d = '0;
            end
            OP_COLUMN, OP_VECTOR: begin
              buf_we    = 1'b1;
              buf_waddr = work_i.slot[RW-1:0];
              buf_wdata = work_i.value;
              if (work_i.last) begin
                kind_d   = (work_i.op == OP_VECTOR);
                status_d = ST_OK;
                pass_d   = 1'b0;
                k_d      = '0;
                l_d      = '0;
                ph_d     = '0;
                sum_d    = '0;
                if (work_i.op == OP_COLUMN && cc_q == LW'(MaxCols)) begin
                  state_d = S_REJECT;
                end else if (!(work_i.op == OP_VECTOR && cc_q == '0)) begin
                  state_d = S_SQ;
                end
              end
            end
            default: begin
              cc_d = cc_q;
            end
          endcase
        end
      end

      S_REJECT: begin
        out_data_o = '{kind: KindR, index: 4'd0, entry: '0, status: ST_FULL,
                       final_res: 1'b1};
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end

      // Sum of squares of the working vector
      S_SQ: begin
        unique case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: begin
            prod_d = mul_a * mul_b;
            ph_d   = 2'd2;
          end
          default: begin
            sum_d = sum_q + SW'(prod_q);
            ph_d  = 2'd0;
            if (k_last) begin
              state_d = S_SQRT;
              srem_d  = '0;
              root_d  = '0;
              scnt_d  = '0;
            end else begin
              k_d = k_q + ECW'(1);
            end
          end
        endcase
      end

      S_SQRT: begin
        srem_d = sq_ge ? (NW+2)'(sq_t - sq_trial) : (NW+2)'(sq_t);
        root_d = {root_q[NW-2:0], sq_ge};
        sum_d  = sum_q << 2;
        scnt_d = scnt_q + SCW'(1);
        if (scnt_q == SCW'(NW - 1)) begin
          nrm_d = root_d;
          k_d   = '0;
          ph_d  = '0;
          if (root_d == '0) begin
            status_d = ST_ZERO;
          end
          if (!pass_q) begin
            state_d = S_SCALE;
          end else begin
            r_we    = 1'b1;
            r_waddr = cc_q[RAW-1:0];
            r_wdata = (root_d > NW'(32'h7fffffff)) ? 32'h7fffffff : root_d[31:0];
            state_d = S_STORE;
          end
        end
      end

      // Scale the loaded vector to unit norm, in place
      S_SCALE: begin
        priority if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else if (ph_q == 2'd1 && nrm_q != '0) begin
          div_start = 1'b1;
          ph_d      = 2'd2;
        end else if (ph_q == 2'd1 || div_done) begin
          buf_we    = 1'b1;
          buf_wdata = (nrm_q == '0) ? '0 : scale_sat(buf_rd[31], div_quo);
          ph_d      = 2'd0;
          if (k_last) begin
            k_d   = '0;
            l_d   = '0;
            acc_d = '0;
            if (kind_q == KindB) begin
              state_d = S_BDOT;
            end else if (cc_q == '0) begin
              state_d = S_SQ;
              pass_d  = 1'b1;
              sum_d   = '0;
            end else begin
              state_d = S_RDOT;
            end
          end else begin
            k_d = k_q + ECW'(1);
          end
        end else begin
          ph_d = ph_q;
        end
      end

      // Dot products of stored columns with the working vector
      S_RDOT, S_BDOT: begin
        unique case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: begin
            prod_d = mul_a * mul_b;
            ph_d   = 2'd2;
          end
          default: begin
            if (!k_last) begin
              acc_d = acc_n;
              k_d   = k_q + ECW'(1);
              ph_d  = 2'd0;
            end else if (state_q == S_RDOT) begin
              r_we    = 1'b1;
              r_wdata = round_q(acc_n);
              acc_d   = '0;
              k_d     = '0;
              ph_d    = 2'd0;
              if (l_last) begin
                l_d     = '0;
                state_d = S_RES;
              end else begin
                l_d = l_q + LW'(1);
              end
            end else if (!out_full_i) begin
              out_push_o = 1'b1;
              out_data_o = '{kind: KindB, index: 4'(l_q), entry: round_q(acc_n),
                             status: status_q, final_res: l_last};
              acc_d = '0;
              k_d   = '0;
              ph_d  = 2'd0;
              if (l_last) begin
                state_d = S_IDLE;
              end else begin
                l_d = l_q + LW'(1);
              end
            end
          end
        endcase
      end

      // Residual: subtract the projection on the stored columns
      S_RES: begin
        unique case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: begin
            prod_d = mul_a * mul_b;
            ph_d   = 2'd2;
          end
          default: begin
            ph_d = 2'd0;
            if (l_last) begin
              buf_we    = 1'b1;
              buf_wdata = sat32(35'(buf_rd) - 35'(round_q(acc_n)));
              l_d       = '0;
              acc_d     = '0;
              if (k_last) begin
                k_d     = '0;
                pass_d  = 1'b1;
                sum_d   = '0;
                state_d = S_SQ;
              end else begin
                k_d = k_q + ECW'(1);
              end
            end else begin
              acc_d = acc_n;
              l_d   = l_q + LW'(1);
            end
          end
        endcase
      end

      // Write the normalised residual as the next Q column
      S_STORE: begin
        priority if (k_q >= rows_i || (ph_q == 2'd1 && nrm_q == '0) ||
                     (ph_q == 2'd2 && div_done)) begin
          q_we    = 1'b1;
          q_wdata = (k_q >= rows_i || nrm_q == '0) ? '0 :
                    scale_sat(buf_rd[31], div_quo);
          ph_d    = 2'd0;
          if (k_q == ECW'(MaxRows - 1)) begin
            cc_d    = cc_q + LW'(1);
            l_d     = '0;
            state_d = S_EMIT;
          end else begin
            k_d = k_q + ECW'(1);
          end
        end else if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else if (ph_q == 2'd1) begin
          div_start = 1'b1;
          ph_d      = 2'd2;
        end else begin
          ph_d = ph_q;
        end
      end

      // Transfer the R column
      S_EMIT: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else if (!out_full_i) begin
          out_push_o = 1'b1;
          out_data_o = '{kind: KindR, index: 4'(l_q), entry: r_rd,
                         status: status_q, final_res: l_last};
          ph_d       = 2'd0;
          if (l_last) begin
            state_d = S_IDLE;
          end else begin
            l_d = l_q + LW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    nrm_q  <= nrm_d;
    sum_q  <= sum_d;
    srem_q <= srem_d;
    root_q <= root_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    kind_q <= kind_d;
    pass_q <= pass_d;
    status_q <= status_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= '0;
      k_q     <= '0;
      l_q     <= '0;
      cc_q    <= '0;
      scnt_q  <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      k_q     <= k_d;
      l_q     <= l_d;
      cc_q    <= cc_d;
      scnt_q  <= scnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cc_q <= LW'(MaxCols))
    else $error("column count beyond store size");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("result transfer into a full queue");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_emit_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT || state_q == S_BDOT) |-> cc_q != '0)
    else $error("R or projection transfer with empty store");
`endif

endmodule

FILE: src/incremental_qr_column_append_core.sv
// Top level of the incremental QR column append core.
// Processing: completing a column vector of n rows with c stored columns runs the first norm
// and scaling, the projections, the residual norm and the store of the column.
// Throughput: elements enter one per cycle while the two-entry work queue has room; the
// serial divider (one bit per cycle) and the single shared multiplier set the completion time.
// Reset: rst_ni is asynchronous, active low; stored columns and element counts are dropped.
module incremental_qr_column_append_core import iqr_pkg::*; #(
  parameter int unsigned MaxRows = MaxRowsDef,
  parameter int unsigned MaxCols = MaxColsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  cmd_item_t   in_data_i,
  output logic        empty,
  input  logic        pop,
  output result_t     out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned ECW = $clog2(MaxRows + 1);
  localparam int unsigned WW  = $bits(work_t);
  localparam int unsigned OW  = $bits(result_t);

  logic [6:0]     rows_q;
  logic [ECW-1:0] rows_n;
  logic           wq_push, wq_full, wq_empty, wq_pop;
  work_t          wq_in;
  logic [WW-1:0]  wq_out;
  logic           oq_push, oq_full;
  result_t        oq_in;
  logic [OW-1:0]  oq_out;

  // Register write on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RowsReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      rows_q <= pwdata[6:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {25'd0, rows_q};

  // Clamp the row count to the supported range
  always_comb begin
    if (rows_q == '0) begin
      rows_n = ECW'(1);
    end else if (32'(rows_q) > 32'(MaxRows)) begin
      rows_n = ECW'(MaxRows);
    end else begin
      rows_n = ECW'(rows_q);
    end
  end

  iqr_front #(.MaxRows(MaxRows)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rows_i    (rows_n),
    .push_i    (push),
    .in_data_i (in_data_i),
    .q_full_i  (wq_full),
    .q_push_o  (wq_push),
    .q_data_o  (wq_in)
  );

  iqr_fifo #(.Width(WW), .Depth(2)) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wq_push),
    .data_i  (wq_in),
    .pop_i   (wq_pop),
    .data_o  (wq_out),
    .full_o  (wq_full),
    .empty_o (wq_empty)
  );

  iqr_back #(.MaxRows(MaxRows), .MaxCols(MaxCols)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rows_i       (rows_n),
    .work_valid_i (!wq_empty),
    .work_i       (work_t'(wq_out)),
    .work_pop_o   (wq_pop),
    .out_full_i   (oq_full),
    .out_push_o   (oq_push),
    .out_data_o   (oq_in)
  );

  iqr_fifo #(.Width(OW), .Depth(4)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .data_i  (oq_in),
    .pop_i   (pop),
    .data_o  (oq_out),
    .full_o  (oq_full),
    .empty_o (empty)
  );

  assign full       = wq_full;
  assign out_data_o = result_t'(oq_out);

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of the incremental QR column append core.
import iqr_pkg::*;

class qr_scoreboard;
  int unsigned  rows_reg;
  int           q_col[16][64];
  int           load_buf[64];
  int           r_col[16];
  int unsigned  col_count;
  int unsigned  elem_count;
  logic         load_is_b;
  result_t      expected_q[$];
  int unsigned  errors;
  int unsigned  checked;
  int unsigned  zero_seen;
  int unsigned  full_seen;
  int unsigned  proj_seen;

  function new();
    rows_reg   = RowsReset;
    col_count  = 0;
    elem_count = 0;
    load_is_b  = 1'b0;
    errors     = 0;
    checked    = 0;
    zero_seen  = 0;
    full_seen  = 0;
    proj_seen  = 0;
    foreach (q_col[l, k]) q_col[l][k] = 0;
    foreach (load_buf[k]) load_buf[k] = 0;
    foreach (r_col[l]) r_col[l] = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function int clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  // Half-up round of a Q4.58 sum back to Q2.29, then saturate
  function int to_q229(logic [63:0] acc);
    logic signed [63:0] t;
    t = acc + (64'd1 << (Frac - 1));
    return clamp32(t >>> Frac);
  endfunction

  function logic [63:0] magnitude(int x);
    longint v;
    v = x;
    return (v < 0) ? -v : v;
  endfunction

  // Floor of the exact square root of the sum of squares
  function logic [63:0] vec_norm(int v[64], int unsigned n);
    logic [127:0] s;
    logic [127:0] c2;
    logic [63:0]  y;
    logic [63:0]  c;
    logic [63:0]  a;
    s = '0;
    y = '0;
    for (int k = 0; k < n; k++) begin
      a = magnitude(v[k]);
      s += {64'd0, a} * {64'd0, a};
    end
    for (int b = 63; b >= 0; b--) begin
      c  = y | (64'd1 << b);
      c2 = {64'd0, c} * {64'd0, c};
      if (c2 <= s) y = c;
    end
    return y;
  endfunction

  function int unit_scale(int x, logic [63:0] nrm);
    logic [63:0] q;
    if (nrm == 0) return 0;
    q = (magnitude(x) << Frac) / nrm;
    if (x < 0) return (q >= 64'h80000000) ? 32'sh80000000 : -int'(q);
    return (q > 64'h7fffffff) ? 32'sh7fffffff : int'(q);
  endfunction

  function void add_result(logic kind, int unsigned idx, int entry, status_e st,
                           logic last);
    result_t r;
    r.kind      = kind;
    r.index     = idx[3:0];
    r.entry     = entry;
    r.status    = st;
    r.final_res = last;
    expected_q.push_back(r);
  endfunction

  function void complete_column(int unsigned n);
    int          mp[64];
    int          res[64];
    logic [63:0] nrm;
    logic [63:0] acc;
    status_e     st;
    int unsigned c;
    c  = col_count;
    st = ST_OK;
    if (c >= 16) begin
      add_result(KindR, 0, 0, ST_FULL, 1'b1);
      return;
    end
    foreach (mp[k]) begin
      mp[k]  = 0;
      res[k] = 0;
    end
    nrm = vec_norm(load_buf, n);
    if (nrm == 0) st = ST_ZERO;
    for (int k = 0; k < n; k++) mp[k] = unit_scale(load_buf[k], nrm);
    // project on the stored Q columns
    for (int l = 0; l < c; l++) begin
      acc = '0;
      for (int k = 0; k < n; k++) acc += longint'(q_col[l][k]) * longint'(mp[k]);
      r_col[l] = to_q229(acc);
    end
    // subtract the projection
    for (int k = 0; k < n; k++) begin
      acc = '0;
      for (int l = 0; l < c; l++) acc += longint'(r_col[l]) * longint'(q_col[l][k]);
      res[k] = clamp32(longint'(mp[k]) - longint'(to_q229(acc)));
    end
    nrm = vec_norm(res, n);
    if (nrm == 0) st = ST_ZERO;
    r_col[c] = (nrm > 64'h7fffffff) ? 32'sh7fffffff : int'(nrm);
    for (int k = 0; k < 64; k++) q_col[c][k] = (k < n) ? unit_scale(res[k], nrm) : 0;
    col_count = c + 1;
    for (int l = 0; l <= c; l++) add_result(KindR, l, r_col[l], st, l == c);
  endfunction

  function void complete_b(int unsigned n);
    int          bp[64];
    logic [63:0] nrm;
    logic [63:0] acc;
    status_e     st;
    foreach (bp[k]) bp[k] = 0;
    nrm = vec_norm(load_buf, n);
    st  = (nrm == 0) ? ST_ZERO : ST_OK;
    for (int k = 0; k < n; k++) bp[k] = unit_scale(load_buf[k], nrm);
    for (int j = 0; j < col_count; j++) begin
      acc = '0;
      for (int k = 0; k < n; k++) acc += longint'(q_col[j][k]) * longint'(bp[k]);
      add_result(KindB, j, to_q229(acc), st, j + 1 == col_count);
    end
  endfunction

  // Note one accepted input transfer and work out what it produces
  function void note_item(cmd_item_t it);
    int unsigned n;
    logic        is_b;
    n = rows_reg;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    if (it.command == CMD_CLEAR) begin
      col_count  = 0;
      elem_count = 0;
      return;
    end
    if (it.command == CMD_NONE) return;
    is_b = (it.command == CMD_VECTOR);
    if (elem_count > 0 && is_b != load_is_b) elem_count = 0;
    load_is_b = is_b;
    if (elem_count >= 64) elem_count = 63;
    load_buf[elem_count] = it.value;
    elem_count++;
    if (elem_count < n) return;
    elem_count = 0;
    if (is_b) complete_b(n);
    else complete_column(n);
  endfunction

  // Compare one result transfer with the oldest expectation
  function void check_result(result_t got);
    result_t want;
    checked++;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result kind=%0d index=%0d entry=%0d status=%0d final=%0d",
               $time, got.kind, got.index, got.entry, got.status, got.final_res);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (want.status == ST_ZERO) zero_seen++;
    if (want.status == ST_FULL) full_seen++;
    if (want.kind == KindB) proj_seen++;
    if (got !== want) begin
      $display("%0t: mismatch expected kind=%0d index=%0d entry=%0d status=%0d final=%0d",
               $time, want.kind, want.index, want.entry, want.status, want.final_res);
      $display("%0t:          actual   kind=%0d index=%0d entry=%0d status=%0d final=%0d",
               $time, got.kind, got.index, got.entry, got.status, got.final_res);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned WatchLimit = 300000;
  localparam int unsigned SettleCyc  = 30000;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  cmd_item_t   in_data_i;
  logic        empty;
  logic        pop;
  result_t     out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  qr_scoreboard sb;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  items_sent;
  int unsigned  idle_cycles;
  logic         in_taken;

  incremental_qr_column_append_core dut (
    .clk_i, .rst_ni, .push, .full, .in_data_i, .empty, .pop, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  // Randomly hold off the result side
  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each result transfer
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(out_data_o);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni && ((pop && !empty) || (push && !full))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one item, with random idle gaps ahead of it
  task automatic send(cmd_e cmd, int val);
    cmd_item_t it;
    it.command = cmd;
    it.value   = val;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_data_i <= it;
    do begin
      @(posedge clk_i);
      in_taken = !full;
    end while (!in_taken);
    sb.note_item(it);
    if (cmd != CMD_NONE) items_sent++;
    @(negedge clk_i);
    in_taken = 1'b0;
  endtask

  task automatic go_quiet();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write the row count register over the configuration port
  task automatic write_rows(logic [6:0] rows);
    go_quiet();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= '0;
    pwdata  <= {25'd0, rows};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.rows_reg = rows;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic int pick_value();
    case ($urandom_range(6))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 0;
      3:       return int'($urandom_range(32'h40000000)) - 32'sh20000000;
      4:       return int'($urandom_range(2047)) - 1024;
      default: return int'($urandom());
    endcase
  endfunction

  // Mostly whole vectors with random content, some noise and broken vectors
  task automatic random_phase(int unsigned rows, int unsigned count);
    int unsigned n;
    int unsigned stop_at;
    int unsigned sel;
    n       = (rows < 1) ? 1 : ((rows > 64) ? 64 : rows);
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        for (int k = 0; k < n; k++) send(CMD_COLUMN, pick_value());
      end else if (sel < 85) begin
        for (int k = 0; k < n; k++) send(CMD_VECTOR, pick_value());
      end else if (sel < 90) begin
        send(CMD_CLEAR, pick_value());
      end else if (sel < 94) begin
        send(CMD_NONE, pick_value());
      end else begin
        // single element of a random kind, which may leave a partial vector
        send($urandom_range(1) ? CMD_VECTOR : CMD_COLUMN, pick_value());
      end
    end
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      default: begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    push           = 1'b0;
    pop            = 1'b0;
    in_data_i      = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_taken       = 1'b0;
    idle_cycles    = 0;
    items_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sb             = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, zero norm, dependent column, projection, ignored command
    write_rows(7'd3);
    send(CMD_VECTOR, 32'sh7fffffff);
    send(CMD_VECTOR, 32'sh80000000);
    send(CMD_VECTOR, 1);
    send(CMD_COLUMN, 32'sh7fffffff);
    send(CMD_COLUMN, 32'sh80000000);
    send(CMD_COLUMN, 1);
    send(CMD_COLUMN, 0);
    send(CMD_COLUMN, 0);
    send(CMD_COLUMN, 0);
    send(CMD_COLUMN, -1);
    send(CMD_VECTOR, 32'sh20000000);
    send(CMD_VECTOR, -32'sh20000000);
    send(CMD_VECTOR, 32'sh55555555);
    send(CMD_NONE, 32'shaaaaaaaa);
    send(CMD_VECTOR, 0);
    send(CMD_VECTOR, 0);
    send(CMD_VECTOR, 0);
    send(CMD_CLEAR, 0);
    send(CMD_VECTOR, 5);
    send(CMD_VECTOR, 6);
    send(CMD_VECTOR, 7);

    // Fill the store past capacity with single-row columns
    write_rows(7'd0);
    for (int k = 0; k < 18; k++) send(CMD_COLUMN, (k % 2) ? -k - 1 : 32'sh7fffffff - k);
    send(CMD_CLEAR, 0);

    // Random phases at several row counts and idling patterns
    for (int p = 0; p < 8; p++) begin
      write_rows((p % 4 == 0) ? 7'd2 : ((p % 4 == 1) ? 7'd4 : ((p % 4 == 2) ? 7'd1 : 7'd5)));
      set_idling(p);
      random_phase(sb.rows_reg, 16);
    end

    // Largest row count: a handful of full-height vectors
    write_rows(7'd127);
    set_idling(3);
    send(CMD_CLEAR, 0);
    for (int k = 0; k < 64; k++) send(CMD_COLUMN, pick_value());
    for (int k = 0; k < 64; k++) send(CMD_VECTOR, pick_value());
    write_rows(7'd64);
    set_idling(0);
    for (int k = 0; k < 64; k++) send(CMD_VECTOR, pick_value());

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);

    $display("Sent %0d items; checked %0d results (%0d projections, %0d zero norm, %0d store full)",
             items_sent, sb.checked, sb.proj_seen, sb.zero_seen, sb.full_seen);
    $display("Row counts 0..127 and four idling patterns exercised, %0d errors", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
